FILE: sv/i4s_pkg.sv
// Shared types, constants and control/status structs for the I420 scaler.
// No dependencies; imported by every module of the block except i4s_ram.
`default_nettype none
package i4s_pkg;

    localparam int MAX_SRC_WIDTH_DEF  = 640;
    localparam int MAX_SRC_HEIGHT_DEF = 480;
    localparam int MAX_DST_WIDTH_DEF  = 1024;
    localparam int MAX_DST_HEIGHT_DEF = 1024;

    localparam int SW_W    = 10;   // src_width register
    localparam int SH_W    = 9;    // src_height register
    localparam int DW_W    = 11;   // dst_width / dst_height registers
    localparam int CFG_W   = 11;   // widest register
    localparam int IDX_W   = 2;
    localparam int STEP_W  = 26;
    localparam int ACC_W   = 27;
    localparam int POS_W   = 11;
    localparam int SADDR_W = 20;   // w*h + 2*(w/2)*(h/2) for 10x9 bit sizes

    localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    localparam logic DIV_X = 1'b0;
    localparam logic DIV_Y = 1'b1;

    localparam int K_Y   = 298;
    localparam int K_RV  = 409;
    localparam int K_GU  = 100;
    localparam int K_GV  = 208;
    localparam int K_BU  = 516;
    localparam int K_RND = 128;
    localparam int Y_OFS = 16;
    localparam int C_OFS = 128;
    localparam logic [7:0] ALPHA = 8'hFF;

    typedef struct packed {
        logic       req_type;
        logic [7:0] src_byte;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pixel_word;
        logic        status;
        logic        end_of_row;
        logic        end_of_frame;
    } out_item_t;

    typedef struct packed {
        logic       load_acc;
        logic       size_calc;
        logic       check;
        logic       div_start;
        logic       div_sel;
        logic       step_latch;
        logic       coord_calc;
        logic       addr_calc;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       conv1;
        logic       conv2;
        logic       emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic not_ready;
        logic frame_start;
        logic div_done;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: sv/i420_scale_to_rgba_unit.sv
// Top level of the I420 to RGBA nearest-neighbor scaler.
// Depends on i4s_pkg, i4s_ctrl, i4s_dp (and through it i4s_ram, i4s_div).
//
//   channel | signals                          | payload
//   --------+----------------------------------+-----------------------------
//   in      | in_valid / in_ready              | in_data  (in_item_t)
//   out     | out_valid / out_ready            | out_data (out_item_t)
//   cfg     | cfg_we, cfg_index                | cfg_data (11 bits)
//
// Load transactions are accepted back to back.
// A pixel transaction runs the size, check, coordinate, address, Y/U/V read,
// two conversion and emit steps; the first pixel of a frame adds two step
// divisions (x, then y) by the one-bit-per-cycle divider.
// A not-ready pixel goes from check straight to emit. Reset is asynchronous; no clearing pass.
// A stalled out channel holds the next pixel in the emit step.
`default_nettype none
module i420_scale_to_rgba_unit
    import i4s_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
    parameter int MAX_DST_WIDTH  = MAX_DST_WIDTH_DEF,
    parameter int MAX_DST_HEIGHT = MAX_DST_HEIGHT_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire in_item_t         in_data,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      out_item_t        out_data
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    i4s_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_req_type (in_data.req_type),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    i4s_dp #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_DST_WIDTH  (MAX_DST_WIDTH),
        .MAX_DST_HEIGHT (MAX_DST_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

FILE: sv/i4s_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module i4s_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/i4s_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, for the step values.
// Depends on i4s_pkg.
`default_nettype none
module i4s_div
    import i4s_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [STEP_W-1:0] num,
    input  wire logic [DW_W-1:0]   den,
    output      logic [STEP_W-1:0] quot,
    output      logic              done
);

    localparam int CNT_W = $clog2(STEP_W + 1);

    logic [STEP_W-1:0] q_reg, q_next;
    logic [DW_W:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DW_W+1:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[STEP_W-1]};
        if (start)
        begin
            q_next    = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(STEP_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift numerator bits out of q while quotient bits shift in
            if (trial >= {1'b0, 1'b0, den})
            begin
                rem_next = (DW_W+1)'(trial - {2'b00, den});
                q_next   = {q_reg[STEP_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW_W:0];
                q_next   = {q_reg[STEP_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

FILE: sv/i4s_ctrl.sv
// Sequencer: handshakes, output valid, and the per-pixel step sequence.
// Depends on i4s_pkg.
`default_nettype none
module i4s_ctrl
    import i4s_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_req_type,
    output      logic     in_ready,
    output      logic     out_valid,
    input  wire logic     out_ready,
    input  wire dp_stat_t stat,
    output      ctl_cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SIZE  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_DXS   = 4'd3;
    localparam logic [3:0] S_DXW   = 4'd4;
    localparam logic [3:0] S_DYS   = 4'd5;
    localparam logic [3:0] S_DYW   = 4'd6;
    localparam logic [3:0] S_COORD = 4'd7;
    localparam logic [3:0] S_ADDR  = 4'd8;
    localparam logic [3:0] S_RDY   = 4'd9;
    localparam logic [3:0] S_RDU   = 4'd10;
    localparam logic [3:0] S_RDV   = 4'd11;
    localparam logic [3:0] S_RDW   = 4'd12;
    localparam logic [3:0] S_CONV1 = 4'd13;
    localparam logic [3:0] S_CONV2 = 4'd14;
    localparam logic [3:0] S_EMIT  = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.load_acc = accept && (in_req_type == REQ_LOAD);
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_req_type == REQ_PIXEL)
                begin
                    state_next = S_SIZE;
                end
            end
            S_SIZE:
            begin
                cmd.size_calc = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.not_ready)
                begin
                    state_next = S_EMIT;
                end
                else if (stat.frame_start)
                begin
                    state_next = S_DXS;
                end
                else
                begin
                    state_next = S_COORD;
                end
            end
            S_DXS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_X;
                state_next    = S_DXW;
            end
            S_DXW:
            begin
                cmd.div_sel = DIV_X;
                if (stat.div_done)
                begin
                    cmd.step_latch = 1'b1;
                    state_next     = S_DYS;
                end
            end
            S_DYS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_Y;
                state_next    = S_DYW;
            end
            S_DYW:
            begin
                cmd.div_sel = DIV_Y;
                if (stat.div_done)
                begin
                    cmd.step_latch = 1'b1;
                    state_next     = S_COORD;
                end
            end
            S_COORD:
            begin
                cmd.coord_calc = 1'b1;
                state_next     = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.addr_calc = 1'b1;
                state_next    = S_RDY;
            end
            S_RDY:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = PLANE_Y;
                state_next = S_RDU;
            end
            S_RDU:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = PLANE_U;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = PLANE_Y;
                state_next  = S_RDV;
            end
            S_RDV:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = PLANE_V;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = PLANE_U;
                state_next  = S_RDW;
            end
            S_RDW:
            begin
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = PLANE_V;
                state_next  = S_CONV1;
            end
            S_CONV1:
            begin
                cmd.conv1  = 1'b1;
                state_next = S_CONV2;
            end
            S_CONV2:
            begin
                cmd.conv2  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.emit)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

endmodule
`default_nettype wire

FILE: sv/i4s_dp.sv
// Datapath: config registers, frame store, position accumulators, address
// math, step divider and BT.601 conversion. Depends on i4s_pkg, i4s_ram, i4s_div.
`default_nettype none
module i4s_dp
    import i4s_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
    parameter int MAX_DST_WIDTH  = MAX_DST_WIDTH_DEF,
    parameter int MAX_DST_HEIGHT = MAX_DST_HEIGHT_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire in_item_t         in_data,
    input  wire ctl_cmd_t         cmd,
    output      dp_stat_t         stat,
    output      out_item_t        out_data
);

    localparam int STORE_CAP = MAX_SRC_WIDTH * MAX_SRC_HEIGHT * 3 / 2;
    localparam int RA_W      = $clog2(STORE_CAP);
    localparam int LC_W      = $clog2(STORE_CAP + 1);

    // configuration
    logic [SW_W-1:0] src_w_reg;
    logic [SH_W-1:0] src_h_reg;
    logic [DW_W-1:0] dst_w_reg, dst_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= '0;
            src_h_reg <= '0;
            dst_w_reg <= DW_W'(1);
            dst_h_reg <= DW_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_w_reg <= cfg_data[SW_W-1:0];
                REG_SRC_HEIGHT: src_h_reg <= cfg_data[SH_W-1:0];
                REG_DST_WIDTH:  dst_w_reg <= cfg_data[DW_W-1:0];
                REG_DST_HEIGHT: dst_h_reg <= cfg_data[DW_W-1:0];
                default:        ;
            endcase
        end
    end

    logic [DW_W-1:0] dw, dh;
    always_comb
    begin
        if (dst_w_reg == '0)
            dw = DW_W'(1);
        else if (32'(dst_w_reg) > MAX_DST_WIDTH)
            dw = DW_W'(MAX_DST_WIDTH);
        else
            dw = dst_w_reg;
        if (dst_h_reg == '0)
            dh = DW_W'(1);
        else if (32'(dst_h_reg) > MAX_DST_HEIGHT)
            dh = DW_W'(MAX_DST_HEIGHT);
        else
            dh = dst_h_reg;
    end

    logic [SW_W-2:0] uvw;
    logic [SH_W-2:0] uvh;
    assign uvw = src_w_reg[SW_W-1:1];
    assign uvh = src_h_reg[SH_W-1:1];

    // load side
    logic [LC_W-1:0] lcount_reg, lcount_next;
    logic [LC_W-1:0] wr_base;
    logic            wr_en;
    assign wr_base = in_data.first_byte ? '0 : lcount_reg;
    assign wr_en   = cmd.load_acc && (32'(wr_base) < STORE_CAP);

    always_comb
    begin
        lcount_next = lcount_reg;
        if (cmd.load_acc)
        begin
            lcount_next = wr_en ? wr_base + 1'b1 : wr_base;
        end
    end

    // sizes and readiness
    logic [SADDR_W-1:0] ysize_reg, uvsize_reg;
    logic               size_ok_reg;
    logic [SADDR_W:0]   need;
    logic               fail_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.size_calc)
        begin
            ysize_reg   <= SADDR_W'(src_w_reg * src_h_reg);
            uvsize_reg  <= SADDR_W'(uvw * uvh);
            size_ok_reg <= (src_w_reg >= SW_W'(2)) && (src_h_reg >= SH_W'(2))
                           && (32'(src_w_reg) <= MAX_SRC_WIDTH)
                           && (32'(src_h_reg) <= MAX_SRC_HEIGHT);
        end
    end

    assign need = {1'b0, ysize_reg} + {uvsize_reg, 1'b0};
    assign stat.not_ready = !size_ok_reg || (32'(lcount_reg) < 32'(need));

    // position
    logic [POS_W-1:0]  col_reg, col_next, row_reg, row_next;
    logic [ACC_W-1:0]  xacc_reg, xacc_next, yacc_reg, yacc_next;
    logic [STEP_W-1:0] xstep_reg, xstep_next, ystep_reg, ystep_next;
    logic              eor, eof;

    assign stat.frame_start = (col_reg == '0) && (row_reg == '0);
    assign eor = (32'(col_reg) + 1) >= 32'(dw);
    assign eof = eor && ((32'(row_reg) + 1) >= 32'(dh));

    // step divider
    logic [STEP_W-1:0] div_num, div_q, step_val;
    logic [DW_W-1:0]   div_den;
    assign div_num = (cmd.div_sel == DIV_X) ? STEP_W'({src_w_reg, 16'h0000})
                                            : STEP_W'({src_h_reg, 16'h0000});
    assign div_den = (cmd.div_sel == DIV_X) ? dw : dh;
    assign step_val = (div_q == '0) ? STEP_W'(1) : div_q;

    i4s_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_q),
        .done  (stat.div_done)
    );

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        xacc_next  = xacc_reg;
        yacc_next  = yacc_reg;
        xstep_next = xstep_reg;
        ystep_next = ystep_reg;
        if (cmd.load_acc && in_data.first_byte)
        begin
            col_next  = '0;
            row_next  = '0;
            xacc_next = '0;
            yacc_next = '0;
        end
        if (cmd.step_latch)
        begin
            if (cmd.div_sel == DIV_X)
                xstep_next = step_val;
            else
                ystep_next = step_val;
            xacc_next = '0;
            yacc_next = '0;
        end
        if (cmd.emit && !fail_reg)
        begin
            if (eof)
            begin
                col_next  = '0;
                row_next  = '0;
                xacc_next = '0;
                yacc_next = '0;
            end
            else if (eor)
            begin
                col_next  = '0;
                row_next  = row_reg + 1'b1;
                xacc_next = '0;
                yacc_next = yacc_reg + ACC_W'(ystep_reg);
            end
            else
            begin
                col_next  = col_reg + 1'b1;
                xacc_next = xacc_reg + ACC_W'(xstep_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcount_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            xacc_reg   <= '0;
            yacc_reg   <= '0;
            xstep_reg  <= '0;
            ystep_reg  <= '0;
        end
        else
        begin
            lcount_reg <= lcount_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            xacc_reg   <= xacc_next;
            yacc_reg   <= yacc_next;
            xstep_reg  <= xstep_next;
            ystep_reg  <= ystep_next;
        end
    end

    // source coordinates, clamped to the last row/column
    logic [ACC_W-17:0] ix_raw, iy_raw;
    logic [SW_W-1:0]   ix_reg;
    logic [SH_W-1:0]   iy_reg;
    logic [SW_W-2:0]   cx_reg;
    logic [SH_W-2:0]   cy_reg;
    logic [SW_W-1:0]   ix_c;
    logic [SH_W-1:0]   iy_c;
    assign ix_raw = xacc_reg[ACC_W-1:16];
    assign iy_raw = yacc_reg[ACC_W-1:16];

    always_comb
    begin
        ix_c = (32'(ix_raw) < 32'(src_w_reg)) ? SW_W'(ix_raw) : src_w_reg - 1'b1;
        iy_c = (32'(iy_raw) < 32'(src_h_reg)) ? SH_W'(iy_raw) : src_h_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.coord_calc)
        begin
            ix_reg <= ix_c;
            iy_reg <= iy_c;
            cx_reg <= (ix_c[SW_W-1:1] < uvw) ? ix_c[SW_W-1:1] : uvw - 1'b1;
            cy_reg <= (iy_c[SH_W-1:1] < uvh) ? iy_c[SH_W-1:1] : uvh - 1'b1;
        end
    end

    logic [SADDR_W-1:0] yaddr_reg, cidx_reg, rd_addr;
    always_ff @(posedge clk)
    begin
        if (cmd.addr_calc)
        begin
            yaddr_reg <= SADDR_W'(iy_reg * src_w_reg) + SADDR_W'(ix_reg);
            cidx_reg  <= SADDR_W'(cy_reg * uvw) + SADDR_W'(cx_reg);
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            PLANE_Y: rd_addr = yaddr_reg;
            PLANE_U: rd_addr = ysize_reg + cidx_reg;
            PLANE_V: rd_addr = ysize_reg + uvsize_reg + cidx_reg;
            default: rd_addr = yaddr_reg;
        endcase
    end

    logic [7:0] rd_data;

    i4s_ram #(
        .WIDTH (8),
        .DEPTH (STORE_CAP)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (RA_W'(wr_base)),
        .wdata (in_data.src_byte),
        .re    (cmd.rd_en),
        .raddr (RA_W'(rd_addr)),
        .rdata (rd_data)
    );

    logic [7:0] yb_reg, ub_reg, vb_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            case (cmd.cap_sel)
                PLANE_Y: yb_reg <= rd_data;
                PLANE_U: ub_reg <= rd_data;
                PLANE_V: vb_reg <= rd_data;
                default: ;
            endcase
        end
    end

    // BT.601 conversion: products, then sums with clamp
    logic signed [9:0]  c_s, d_s, e_s;
    logic signed [20:0] py_reg, prv_reg, pgu_reg, pgv_reg, pbu_reg;
    logic signed [22:0] sr, sg, sb;
    logic [7:0]         r_reg, g_reg, b_reg;

    assign c_s = $signed({2'b00, yb_reg}) - 10'sd16;
    assign d_s = $signed({2'b00, ub_reg}) - 10'sd128;
    assign e_s = $signed({2'b00, vb_reg}) - 10'sd128;

    always_ff @(posedge clk)
    begin
        if (cmd.conv1)
        begin
            py_reg  <= 21'(c_s * 12'sd298);
            prv_reg <= 21'(e_s * 12'sd409);
            pgu_reg <= 21'(d_s * 12'sd100);
            pgv_reg <= 21'(e_s * 12'sd208);
            pbu_reg <= 21'(d_s * 12'sd516);
        end
    end

    assign sr = 23'(py_reg) + 23'(prv_reg) + 23'sd128;
    assign sg = 23'(py_reg) - 23'(pgu_reg) - 23'(pgv_reg) + 23'sd128;
    assign sb = 23'(py_reg) + 23'(pbu_reg) + 23'sd128;

    function automatic logic [7:0] clamp8(input logic signed [22:0] v);
        logic signed [14:0] q;
        q = 15'(v >>> 8);
        if (q < 0)
            return 8'd0;
        else if (q > 15'sd255)
            return 8'd255;
        else
            return q[7:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.conv2)
        begin
            r_reg <= clamp8(sr);
            g_reg <= clamp8(sg);
            b_reg <= clamp8(sb);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            fail_reg <= stat.not_ready;
        end
    end

    // output register
    out_item_t out_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (fail_reg)
            begin
                out_reg.pixel_word   <= '0;
                out_reg.status       <= 1'b1;
                out_reg.end_of_row   <= 1'b0;
                out_reg.end_of_frame <= 1'b0;
            end
            else
            begin
                out_reg.pixel_word   <= {ALPHA, b_reg, g_reg, r_reg};
                out_reg.status       <= 1'b0;
                out_reg.end_of_row   <= eor;
                out_reg.end_of_frame <= eof;
            end
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

FILE: sv/i4s_checker.sv
// Port-level checks for the scaler top level, attached by bind.
// Depends on i4s_pkg and i420_scale_to_rgba_unit.
`default_nettype none
module i4s_checker
    import i4s_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("out transaction changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |->
            out_data.pixel_word == 32'd0 && !out_data.end_of_row
            && !out_data.end_of_frame)
        else $error("not-ready result carries data");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.status |-> out_data.pixel_word[31:24] == ALPHA)
        else $error("alpha byte wrong");

    a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.end_of_frame |-> out_data.end_of_row)
        else $error("end of frame without end of row");

endmodule

bind i420_scale_to_rgba_unit i4s_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

FILE: tb/i420_scale_to_rgba_unit_tb.sv
// Testbench for i420_scale_to_rgba_unit: loads small I420 frames and pulls scaled RGBA pixels.
// Depends on i4s_pkg and the block's RTL; a scoreboard class predicts and checks pixels.
`timescale 1ns / 1ps
`default_nettype none

module i420_scale_to_rgba_unit_tb;
    import i4s_pkg::*;

    localparam int STORE_CAP = MAX_SRC_WIDTH_DEF * MAX_SRC_HEIGHT_DEF * 3 / 2;

    class pixel_scoreboard;
        byte unsigned store[int];
        int unsigned  load_count;
        int unsigned  col, row;
        longint unsigned x_acc, y_acc, x_step, y_step;
        int unsigned  sw, sh, dw_reg, dh_reg;
        out_item_t    pending[$];
        int           errors;

        function new();
            load_count = 0; col = 0; row = 0;
            x_acc = 0; y_acc = 0; x_step = 0; y_step = 0;
            sw = 0; sh = 0; dw_reg = 1; dh_reg = 1; errors = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, int unsigned v);
            case (idx)
                REG_SRC_WIDTH:  sw = v & 'h3FF;
                REG_SRC_HEIGHT: sh = v & 'h1FF;
                REG_DST_WIDTH:  dw_reg = v & 'h7FF;
                default:        dh_reg = v & 'h7FF;
            endcase
        endfunction

        function int unsigned clamp8(int v);
            int q;
            q = v >>> 8;
            if (q < 0) return 0;
            if (q > 255) return 255;
            return q;
        endfunction

        function int unsigned eff(int unsigned v, int unsigned m);
            if (v == 0) return 1;
            return (v > m) ? m : v;
        endfunction

        function void note_input(in_item_t it);
            out_item_t   o;
            int unsigned dw, dh, uvw, uvh, ysz, uvsz, iy, ix, cy, cx, ci, r, g, b;
            int          c, d, e;
            bit          eor, eof;
            if (it.req_type == REQ_LOAD)
            begin
                if (it.first_byte)
                begin
                    load_count = 0; col = 0; row = 0; x_acc = 0; y_acc = 0;
                end
                if (load_count < STORE_CAP)
                begin
                    store[load_count] = it.src_byte;
                    load_count++;
                end
                return;
            end
            o = '0;
            dw = eff(dw_reg, MAX_DST_WIDTH_DEF);
            dh = eff(dh_reg, MAX_DST_HEIGHT_DEF);
            uvw = sw / 2; uvh = sh / 2;
            ysz = sw * sh; uvsz = uvw * uvh;
            if (sw < 2 || sh < 2 || sw > MAX_SRC_WIDTH_DEF || sh > MAX_SRC_HEIGHT_DEF
                || load_count < ysz + 2 * uvsz)
            begin
                o.status = 1'b1;
                pending.push_back(o);
                return;
            end
            if (col == 0 && row == 0)
            begin
                x_step = (longint'(sw) << 16) / dw;
                if (x_step == 0) x_step = 1;
                y_step = (longint'(sh) << 16) / dh;
                if (y_step == 0) y_step = 1;
                x_acc = 0; y_acc = 0;
            end
            iy = ((y_acc >> 16) < sh) ? int'(y_acc >> 16) : sh - 1;
            ix = ((x_acc >> 16) < sw) ? int'(x_acc >> 16) : sw - 1;
            cy = ((iy >> 1) < uvh) ? (iy >> 1) : uvh - 1;
            cx = ((ix >> 1) < uvw) ? (ix >> 1) : uvw - 1;
            ci = cy * uvw + cx;
            c = int'(store[iy * sw + ix]) - Y_OFS;
            d = int'(store[ysz + ci]) - C_OFS;
            e = int'(store[ysz + uvsz + ci]) - C_OFS;
            r = clamp8(K_Y * c + K_RV * e + K_RND);
            g = clamp8(K_Y * c - K_GU * d - K_GV * e + K_RND);
            b = clamp8(K_Y * c + K_BU * d + K_RND);
            eor = (col + 1 >= dw);
            eof = eor && (row + 1 >= dh);
            o.pixel_word = {ALPHA, b[7:0], g[7:0], r[7:0]};
            o.end_of_row = eor;
            o.end_of_frame = eof;
            pending.push_back(o);
            if (eof)
            begin
                col = 0; row = 0; x_acc = 0; y_acc = 0;
            end
            else if (eor)
            begin
                col = 0; row++; x_acc = 0; y_acc += y_step;
            end
            else
            begin
                col++; x_acc += x_step;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected pixel transaction %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.pixel_word !== exp.pixel_word)
            begin
                $error("pixel_word exp %h got %h", exp.pixel_word, got.pixel_word);
                errors++;
            end
            if (got.status !== exp.status)
            begin
                $error("status exp %b got %b", exp.status, got.status);
                errors++;
            end
            if (got.end_of_row !== exp.end_of_row)
            begin
                $error("end_of_row exp %b got %b", exp.end_of_row, got.end_of_row);
                errors++;
            end
            if (got.end_of_frame !== exp.end_of_frame)
            begin
                $error("end_of_frame exp %b got %b", exp.end_of_frame, got.end_of_frame);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = REG_SRC_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    in_item_t         in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_item_t        out_data;

    pixel_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    i420_scale_to_rgba_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stall, check on accepted transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // valid stays high between back-to-back transactions; dropped only when idling or draining
    task automatic send_item(logic rt, logic [7:0] bv, logic fb);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{req_type: rt, src_byte: bv, first_byte: fb};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(in_data);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[CFG_W-1:0];
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
    endtask

    task automatic set_sizes(int unsigned w, int unsigned h, int unsigned dw, int unsigned dh);
        drain();
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
        cfg_we <= 1'b0;
    endtask

    task automatic load_frame(int unsigned n, bit extremes);
        logic [7:0] bv;
        for (int i = 0; i < n; i++)
        begin
            bv = extremes ? (($urandom_range(1)) ? 8'hFF : 8'h00) : 8'($urandom);
            send_item(REQ_LOAD, bv, i == 0);
        end
    endtask

    task automatic pixels(int n);
        for (int i = 0; i < n; i++)
            send_item(REQ_PIXEL, 8'($urandom), 1'($urandom));
    endtask

    function automatic int unsigned frame_bytes(int unsigned w, int unsigned h);
        return w * h + 2 * (w / 2) * (h / 2);
    endfunction

    initial
    begin
        int unsigned w, h, dw, dh, sel;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: not ready at reset size, then incomplete frame
        pixels(2);
        set_sizes(2, 2, 0, 0);
        load_frame(3, 0);
        pixels(1);
        send_item(REQ_LOAD, 8'hFF, 1'b0);
        send_item(REQ_LOAD, 8'h00, 1'b0);
        send_item(REQ_LOAD, 8'hFF, 1'b0);
        pixels(2);
        set_sizes(3, 3, 5, 3);
        load_frame(frame_bytes(3, 3), 1);
        pixels(4);
        // shrink output mid-frame
        set_sizes(3, 3, 2, 1);
        pixels(2);
        set_sizes(1, 3, 2, 2);
        pixels(1);
        set_sizes(641, 480, 2047, 2047);
        pixels(1);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 52; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 52; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            for (int f = 0; f < 4; f++)
            begin
                sel = $urandom_range(7);
                w = $urandom_range(2, 5);
                h = $urandom_range(2, 4);
                dw = $urandom_range(1, 6);
                dh = $urandom_range(1, 4);
                if (sel == 0) dw = 0;
                if (sel == 1) dh = 1024;
                if (sel == 2) dw = 1;
                set_sizes(w, h, dw, dh);
                load_frame(frame_bytes(w, h) - ((sel == 3) ? 1 : 0), sel == 4);
                pixels($urandom_range(4, 14));
            end
        end
        drain();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

FILE: i420_scale_to_rgba_unit.f
sv/i4s_pkg.sv
sv/i4s_ram.sv
sv/i4s_div.sv
sv/i4s_ctrl.sv
sv/i4s_dp.sv
sv/i420_scale_to_rgba_unit.sv
sv/i4s_checker.sv
tb/i420_scale_to_rgba_unit_tb.sv
